// File: design/rgb_gaussian_color_probability_macros.svh
// Assertion macros used by the top-level design file.
`ifndef RGB_GAUSSIAN_COLOR_PROBABILITY_MACROS_SVH
`define RGB_GAUSSIAN_COLOR_PROBABILITY_MACROS_SVH

`ifndef SYNTH
`define RGBG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbg assertion failed");
`define RGBG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbg assertion failed");
`else
`define RGBG_ASSERT_IMP(name, ante, cons)
`define RGBG_ASSERT_NXT(name, ante, cons)
`endif

`endif

// File: design/rgbg_pkg.sv
`default_nettype none

package rgbg_pkg;

  localparam int EXP_TABLE_DEPTH = 256;
  localparam int ROM_K_W = $clog2(EXP_TABLE_DEPTH);
  localparam int ROM_W = 17;

  localparam int PIX_W = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 48;
  localparam int COEF_W = 32;
  localparam int GAIN_W = 16;
  localparam int MEAN_W = 16;
  localparam int DIFF_W = 18;
  localparam int DD_W = 34;
  localparam int HI_W = 50;
  localparam int LO_W = 51;
  localparam int HI_SUM_W = 53;
  localparam int LO_SUM_W = 54;
  localparam int TOTAL_W = 70;
  localparam int FORM_FULL_W = TOTAL_W - 32;
  localparam int FORM_W = 35;
  localparam int DIST_W = 34;
  localparam int PROB_W = 16;
  localparam int X_W = 40;
  localparam int Y_W = 25;
  localparam int FRAC_W = 20;
  localparam int N_W = Y_W - FRAC_W;
  localparam int NUM_COEF = 6;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic signed [FORM_W-1:0] FORM_MAX = 35'sh3_FFFF_FFFF;
  localparam logic signed [FORM_W-1:0] FORM_MIN = 35'sh4_0000_0000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2048;
  localparam logic [PROB_W-1:0] PROB_ONE = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN_RGB = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RR = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_GG = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BB = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_RG = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_RB = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_GB = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FACTOR = 4'd7;

  // Coefficient order: rr, gg, bb, rg, rb, gb.
  typedef struct packed {
    logic [3*MEAN_W-1:0] mean_rgb;
    logic [NUM_COEF-1:0][COEF_W-1:0] coef;
    logic [GAIN_W-1:0] gain_factor;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  typedef logic [ROM_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  // Rounded Q1.16 samples of exp(-ln2*k/DEPTH) from a 13-term series in Q.30.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    logic [63:0] u;
    logic [63:0] acc;
    logic [63:0] term;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      u = (LN2_Q30 * 64'(k)) / 64'(EXP_TABLE_DEPTH);
      acc = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int i = 1; i <= 12; i++) begin
        term = ((term * u) >> 30) / 64'(i);
        if (i % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      rom[k] = ROM_W'((acc + 64'd8192) >> 14);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

// File: design/rgbg_pix_if.sv
`default_nettype none

interface rgbg_pix_if;
  import rgbg_pkg::*;
  logic valid;
  logic ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// File: design/rgbg_res_if.sv
`default_nettype none

interface rgbg_res_if;
  import rgbg_pkg::*;
  logic valid;
  logic ready;
  logic signed [FORM_W-1:0] form_value;
  logic [PROB_W-1:0] probability;
  logic [DIST_W-1:0] distance_sq;
  logic negative_form;
  modport source (output valid, form_value, probability, distance_sq, negative_form,
                  input ready);
  modport sink (input valid, form_value, probability, distance_sq, negative_form,
                output ready);
endinterface

`default_nettype wire

// File: design/rgbg_cfg_if.sv
`default_nettype none

interface rgbg_cfg_if;
  import rgbg_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/rgb_gaussian_color_probability.sv
// Throughput: one pixel per cycle; the 8-stage pipeline advances whenever the
// output register is empty or its result is being taken, so stalls hold every stage.
// Configuration writes are taken every cycle.
// Synchronous reset clears all valid bits and returns the registers to their reset
// values: zero mean and matrix, gain 0.5.
`default_nettype none

`include "rgb_gaussian_color_probability_macros.svh"

module rgb_gaussian_color_probability (
  input  logic        clk,
  input  logic        rst,
  rgbg_cfg_if.sink    cfg,
  rgbg_pix_if.sink    pix,
  rgbg_res_if.source  res
);
  import rgbg_pkg::*;

  cfg_t cfg_reg;
  logic en;
  logic quad_vld;
  logic signed [FORM_W-1:0] quad_form;
  logic [DIST_W-1:0] quad_dist;
  pipe_ctl_t quad_ctl;
  pipe_ctl_t prob_ctl;

  assign cfg.ready = 1'b1;
  assign en = !res.valid || res.ready;
  assign pix.ready = en;
  assign quad_ctl = '{en: en, vld: pix.valid};
  assign prob_ctl = '{en: en, vld: quad_vld};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.mean_rgb <= '0;
      cfg_reg.coef <= '0;
      cfg_reg.gain_factor <= GAIN_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MEAN_RGB:    cfg_reg.mean_rgb <= cfg.data;
        REG_INV_RR:      cfg_reg.coef[0] <= cfg.data[COEF_W-1:0];
        REG_INV_GG:      cfg_reg.coef[1] <= cfg.data[COEF_W-1:0];
        REG_INV_BB:      cfg_reg.coef[2] <= cfg.data[COEF_W-1:0];
        REG_CROSS_RG:    cfg_reg.coef[3] <= cfg.data[COEF_W-1:0];
        REG_CROSS_RB:    cfg_reg.coef[4] <= cfg.data[COEF_W-1:0];
        REG_CROSS_GB:    cfg_reg.coef[5] <= cfg.data[COEF_W-1:0];
        REG_GAIN_FACTOR: cfg_reg.gain_factor <= cfg.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rgbg_quad u_quad (
    .clk         (clk),
    .rst         (rst),
    .ctl         (quad_ctl),
    .cfg         (cfg_reg),
    .red         (pix.red),
    .green       (pix.green),
    .blue        (pix.blue),
    .vld         (quad_vld),
    .form_value  (quad_form),
    .distance_sq (quad_dist)
  );

  rgbg_prob u_prob (
    .clk           (clk),
    .rst           (rst),
    .ctl           (prob_ctl),
    .gain_factor   (cfg_reg.gain_factor),
    .form_in       (quad_form),
    .dist_in       (quad_dist),
    .vld           (res.valid),
    .form_value    (res.form_value),
    .probability   (res.probability),
    .distance_sq   (res.distance_sq),
    .negative_form (res.negative_form)
  );

  `RGBG_ASSERT_IMP(a_neg_sign, res.valid && res.negative_form, res.form_value[FORM_W-1])
  `RGBG_ASSERT_IMP(a_neg_prob, res.valid && res.negative_form, res.probability == PROB_ONE)
  `RGBG_ASSERT_IMP(a_zero_prob, res.valid && res.form_value == '0,
                   res.probability == PROB_ONE && !res.negative_form)
  `RGBG_ASSERT_NXT(a_stall_hold, res.valid && !res.ready, res.valid && $stable(res.form_value))

endmodule

`default_nettype wire

// File: design/rgbg_quad.sv
`default_nettype none

module rgbg_quad (
  input  logic                                    clk,
  input  logic                                    rst,
  input  rgbg_pkg::pipe_ctl_t                     ctl,
  input  rgbg_pkg::cfg_t                          cfg,
  input  logic [rgbg_pkg::PIX_W-1:0]              red,
  input  logic [rgbg_pkg::PIX_W-1:0]              green,
  input  logic [rgbg_pkg::PIX_W-1:0]              blue,
  output logic                                    vld,
  output logic signed [rgbg_pkg::FORM_W-1:0]      form_value,
  output logic [rgbg_pkg::DIST_W-1:0]             distance_sq
);
  import rgbg_pkg::*;

  localparam int PAIR_A [NUM_COEF] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_B [NUM_COEF] = '{0, 1, 2, 1, 2, 2};
  localparam logic signed [TOTAL_W-1:0] ROUND_BIAS = 70'sh8000_0000;

  logic [3:0] vld_pipe;
  logic [PIX_W-1:0] pix [3];
  logic signed [DIFF_W-1:0] diff [3];
  logic signed [2*DIFF_W-1:0] prod [NUM_COEF];
  logic signed [DD_W-1:0] dd [NUM_COEF];
  logic signed [HI_W-1:0] hi_term [NUM_COEF];
  logic signed [LO_W-1:0] lo_term [NUM_COEF];
  logic [DIST_W-1:0] dist3;
  logic [DIST_W-1:0] dist4;
  logic signed [HI_SUM_W-1:0] hi_sum;
  logic signed [LO_SUM_W-1:0] lo_sum;
  logic signed [HI_SUM_W-1:0] hi_sum_next;
  logic signed [LO_SUM_W-1:0] lo_sum_next;
  logic signed [TOTAL_W-1:0] total;
  logic signed [FORM_FULL_W-1:0] form_full;
  logic signed [FORM_W-1:0] form_next;

  assign pix[0] = red;
  assign pix[1] = green;
  assign pix[2] = blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
      vld <= 1'b0;
    end else if (ctl.en) begin
      vld_pipe <= {vld_pipe[2:0], ctl.vld};
      vld <= vld_pipe[3];
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_COEF; j++) begin
      prod[j] = diff[PAIR_A[j]] * diff[PAIR_B[j]];
    end
  end

  always_comb begin
    hi_sum_next = '0;
    lo_sum_next = '0;
    for (int j = 0; j < NUM_COEF; j++) begin
      hi_sum_next = hi_sum_next + HI_SUM_W'(hi_term[j]);
      lo_sum_next = lo_sum_next + LO_SUM_W'(lo_term[j]);
    end
  end

  // Round the Q.40 sum to Q.8, half up, and clamp to the result range.
  always_comb begin
    total = (TOTAL_W'(hi_sum) <<< 16) + TOTAL_W'(lo_sum) + ROUND_BIAS;
    form_full = total[TOTAL_W-1:32];
    if (form_full > FORM_FULL_W'(FORM_MAX)) begin
      form_next = FORM_MAX;
    end else if (form_full < FORM_FULL_W'(FORM_MIN)) begin
      form_next = FORM_MIN;
    end else begin
      form_next = form_full[FORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int c = 0; c < 3; c++) begin
        diff[c] <= $signed({2'b00, pix[c], 8'h00})
                 - $signed({2'b00, cfg.mean_rgb[MEAN_W*(2-c) +: MEAN_W]});
      end
      for (int j = 0; j < NUM_COEF; j++) begin
        dd[j] <= prod[j][DD_W-1:0];
        hi_term[j] <= dd[j] * $signed(cfg.coef[j][COEF_W-1:16]);
        lo_term[j] <= dd[j] * $signed({1'b0, cfg.coef[j][15:0]});
      end
      dist3 <= {1'b0, dd[0][DD_W-2:0]} + {1'b0, dd[1][DD_W-2:0]}
             + {1'b0, dd[2][DD_W-2:0]};
      hi_sum <= hi_sum_next;
      lo_sum <= lo_sum_next;
      dist4 <= dist3;
      form_value <= form_next;
      distance_sq <= dist4;
    end
  end

endmodule

`default_nettype wire

// File: design/rgbg_prob.sv
`default_nettype none

module rgbg_prob (
  input  logic                                    clk,
  input  logic                                    rst,
  input  rgbg_pkg::pipe_ctl_t                     ctl,
  input  logic [rgbg_pkg::GAIN_W-1:0]             gain_factor,
  input  logic signed [rgbg_pkg::FORM_W-1:0]      form_in,
  input  logic [rgbg_pkg::DIST_W-1:0]             dist_in,
  output logic                                    vld,
  output logic signed [rgbg_pkg::FORM_W-1:0]      form_value,
  output logic [rgbg_pkg::PROB_W-1:0]             probability,
  output logic [rgbg_pkg::DIST_W-1:0]             distance_sq,
  output logic                                    negative_form
);
  import rgbg_pkg::*;

  localparam int KPROD_W = FRAC_W + ROM_K_W + 1;

  logic [1:0] vld_pipe;
  logic [X_W-1:0] x6;
  logic neg6;
  logic big6;
  logic signed [FORM_W-1:0] form6;
  logic [DIST_W-1:0] dist6;
  logic [Y_W-1:0] y7;
  logic neg7;
  logic sat7;
  logic signed [FORM_W-1:0] form7;
  logic [DIST_W-1:0] dist7;
  logic [X_W-1:0] x_next;
  logic [2*Y_W+5-1:0] y_prod;
  logic [N_W-1:0] n;
  logic [KPROD_W-1:0] kprod;
  logic [ROM_K_W-1:0] k;
  logic [ROM_W-1:0] t;
  logic [ROM_W:0] t_round;
  logic [ROM_W-1:0] t_shift;
  logic [PROB_W-1:0] prob_next;

  assign x_next = gain_factor * form_in[23:0];
  assign y_prod = x6[23:0] * LOG2E_Q30;

  always_comb begin
    n = y7[Y_W-1:FRAC_W];
    kprod = y7[FRAC_W-1:0] * KPROD_W'(EXP_TABLE_DEPTH);
    k = kprod[FRAC_W +: ROM_K_W];
    t = EXP_ROM[k];
    t_round = (ROM_W+1)'(t >> (n - N_W'(1))) + (ROM_W+1)'(1);
    if (n == '0) begin
      t_shift = t;
    end else begin
      t_shift = t_round[ROM_W:1];
    end
    if (neg7) begin
      prob_next = PROB_ONE;
    end else if (sat7) begin
      prob_next = '0;
    end else if (t_shift > ROM_W'(PROB_ONE)) begin
      prob_next = PROB_ONE;
    end else begin
      prob_next = t_shift[PROB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
      vld <= 1'b0;
    end else if (ctl.en) begin
      vld_pipe <= {vld_pipe[0], ctl.vld};
      vld <= vld_pipe[1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      x6 <= x_next;
      neg6 <= form_in[FORM_W-1];
      big6 <= (form_in[FORM_W-2:24] != '0) && (gain_factor != '0);
      form6 <= form_in;
      dist6 <= dist_in;
      y7 <= y_prod[30 +: Y_W];
      neg7 <= neg6;
      sat7 <= big6 || (x6[X_W-1:24] != '0);
      form7 <= form6;
      dist7 <= dist6;
      form_value <= form7;
      probability <= prob_next;
      distance_sq <= dist7;
      negative_form <= neg7;
    end
  end

endmodule

`default_nettype wire
